### sv/node_load_running_averages_core_macros.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef NODE_LOAD_RUNNING_AVERAGES_CORE_MACROS_SVH
`define NODE_LOAD_RUNNING_AVERAGES_CORE_MACROS_SVH

// same-cycle implication
`define NLRA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NLRA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nlra_pkg.sv
package nlra_pkg;

  localparam int unsigned MAX_LANES   = 8;
  localparam int unsigned THREAD_W    = 9;
  localparam int unsigned MAX_THREADS = 256;
  localparam int unsigned ACTIVE_W    = 4;
  localparam int unsigned MEM_W       = 32;
  localparam int unsigned LOAD_OUT_W  = 17;
  localparam int unsigned STALL_W     = 40;
  localparam int unsigned STALL_FRAC  = 8;
  localparam int unsigned RUN_W       = 32;
  localparam int unsigned BUSY_SUM_W  = 12;
  localparam int unsigned CPU_DEN_W   = 12;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CPUS,
    REG_THREADS_PER_CPU,
    REG_TOTAL_MEMORY
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [MEM_W-1:0]     wdata;
  } cfg_t;

  typedef struct packed {
    logic [THREAD_W-1:0] free_threads_0;
    logic [THREAD_W-1:0] free_threads_1;
    logic [THREAD_W-1:0] free_threads_2;
    logic [THREAD_W-1:0] free_threads_3;
    logic [THREAD_W-1:0] free_threads_4;
    logic [THREAD_W-1:0] free_threads_5;
    logic [THREAD_W-1:0] free_threads_6;
    logic [THREAD_W-1:0] free_threads_7;
    logic [MEM_W-1:0]    mem_free;
  } in_t;

  typedef struct packed {
    logic [LOAD_OUT_W-1:0] cpu_load_now;
    logic [LOAD_OUT_W-1:0] memory_load_now;
    logic [LOAD_OUT_W-1:0] mean_cpu_load;
    logic [LOAD_OUT_W-1:0] mean_memory_load;
    logic [STALL_W-1:0]    mean_stall_ticks;
    logic [RUN_W-1:0]      idle_run_ticks;
  } out_t;

  // shared lane control
  typedef struct packed {
    logic                load;
    logic [THREAD_W-1:0] tpc;
  } lane_ctl_t;

endpackage

### sv/nlra_if.sv
interface nlra_cfg_if;
  logic            valid;
  logic            ready;
  nlra_pkg::cfg_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nlra_in_if;
  logic           valid;
  logic           ready;
  nlra_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nlra_out_if;
  logic           valid;
  logic           ready;
  nlra_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/node_load_running_averages_core.sv
// per accepted word: stall fold if an idle run closes, then memory and CPU load divide and fold
//   into their means; NW = max(33+LOAD_FRAC_BITS, max(40,COUNT_BITS)+1), 49 at default parameters
// all divisions share one restoring divider that resolves one quotient bit per cycle
// flow: one word at a time; the next word is taken once the sequencer is back in idle, and a
//   result still held by the receiver stalls the sequencer in S_DONE until it is taken
// reset: config registers go to 1, averages, counters and idle run to 0, no clearing pass
`include "node_load_running_averages_core_macros.svh"

module node_load_running_averages_core #(
  parameter int unsigned CPU_LANES      = 8,
  parameter int unsigned LOAD_FRAC_BITS = 16,
  parameter int unsigned COUNT_BITS     = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nlra_cfg_if.sink     cfg_i,
  nlra_in_if.sink      in_i,
  nlra_out_if.source   out_o
);
  import nlra_pkg::*;

  localparam int unsigned LW  = LOAD_FRAC_BITS + 1;
  localparam int unsigned FW  = ((STALL_W > COUNT_BITS) ? STALL_W : COUNT_BITS) + 1;
  localparam int unsigned NW  = ((MEM_W + 1 + LOAD_FRAC_BITS) > FW) ?
                                (MEM_W + 1 + LOAD_FRAC_BITS) : FW;
  localparam int unsigned DW  = ((COUNT_BITS + 1) > MEM_W) ? (COUNT_BITS + 1) : MEM_W;
  localparam logic [LW-1:0] LOAD_ONE = {1'b1, {LOAD_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD_DIV,
    S_WAIT_LOAD,
    S_FOLD_GAP,
    S_FOLD_START,
    S_WAIT_FOLD,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_STALL,
    OP_MEM,
    OP_CPU
  } op_e;

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // configuration
  logic [ACTIVE_W-1:0] act_cpus_q;
  logic [THREAD_W-1:0] tpc_cfg_q;
  logic [MEM_W-1:0]    total_cfg_q;

  assign cfg_i.ready = rst_ni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cpus_q  <= ACTIVE_W'(1);
      tpc_cfg_q   <= THREAD_W'(1);
      total_cfg_q <= MEM_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.reg_idx)
        REG_ACTIVE_CPUS:     act_cpus_q  <= cfg_i.payload.wdata[ACTIVE_W-1:0];
        REG_THREADS_PER_CPU: tpc_cfg_q   <= cfg_i.payload.wdata[THREAD_W-1:0];
        REG_TOTAL_MEMORY:    total_cfg_q <= cfg_i.payload.wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e                state_q;
  op_e                   op_q;
  logic [MEM_W-1:0]      free_q;
  logic [MEM_W-1:0]      total_q;
  logic                  idle_q;
  logic [ACTIVE_W-1:0]   lanes_q;
  logic [THREAD_W-1:0]   tpc_q;
  logic [CPU_DEN_W-1:0]  den_cpu_q;
  logic [RUN_W-1:0]      idle_run_q;
  logic [LW-1:0]         avg_cpu_q;
  logic [COUNT_BITS-1:0] cpu_samples_q;
  logic [LW-1:0]         avg_mem_q;
  logic [COUNT_BITS-1:0] mem_samples_q;
  logic [STALL_W-1:0]    avg_stall_q;
  logic [COUNT_BITS-1:0] stall_runs_q;
  logic [LW-1:0]         mem_now_q;
  logic [LW-1:0]         cpu_now_q;
  logic [STALL_W-1:0]    fa_q;
  logic [COUNT_BITS-1:0] fn_q;
  logic [STALL_W-1:0]    fx_q;
  logic [COUNT_BITS:0]   fd_q;
  logic [COUNT_BITS-1:0] fh_q;
  logic [STALL_W-1:0]    gap_q;
  logic                  ge_q;
  logic                  sub_q;
  logic                  out_valid_q;
  out_t                  out_q;

  // effective configuration
  logic [ACTIVE_W-1:0] lanes_eff;
  logic [THREAD_W-1:0] tpc_eff;
  logic [MEM_W-1:0]    total_eff;
  logic [MEM_W-1:0]    free_clamped;
  logic                in_acc;

  always_comb begin
    if (act_cpus_q == '0) begin
      lanes_eff = ACTIVE_W'(1);
    end else if (act_cpus_q > ACTIVE_W'(CPU_LANES)) begin
      lanes_eff = ACTIVE_W'(CPU_LANES);
    end else begin
      lanes_eff = act_cpus_q;
    end
    if (tpc_cfg_q == '0) begin
      tpc_eff = THREAD_W'(1);
    end else if (tpc_cfg_q > THREAD_W'(MAX_THREADS)) begin
      tpc_eff = THREAD_W'(MAX_THREADS);
    end else begin
      tpc_eff = tpc_cfg_q;
    end
    total_eff = (total_cfg_q == '0) ? MEM_W'(1) : total_cfg_q;
  end

  assign free_clamped = (in_i.payload.mem_free > total_eff) ? total_eff
                                                            : in_i.payload.mem_free;
  assign in_i.ready   = (state_q == S_IDLE) && rst_ni;
  assign in_acc       = in_i.valid && in_i.ready;

  // lanes
  logic [THREAD_W-1:0]   free_all [MAX_LANES];
  logic [CPU_LANES-1:0]  lane_act;
  logic [THREAD_W-1:0]   busy_w [CPU_LANES];
  logic [BUSY_SUM_W-1:0] busy_sum;
  lane_ctl_t             lane_ctl;

  assign free_all[0] = in_i.payload.free_threads_0;
  assign free_all[1] = in_i.payload.free_threads_1;
  assign free_all[2] = in_i.payload.free_threads_2;
  assign free_all[3] = in_i.payload.free_threads_3;
  assign free_all[4] = in_i.payload.free_threads_4;
  assign free_all[5] = in_i.payload.free_threads_5;
  assign free_all[6] = in_i.payload.free_threads_6;
  assign free_all[7] = in_i.payload.free_threads_7;

  assign lane_ctl.load = in_acc;
  assign lane_ctl.tpc  = tpc_eff;

  for (genvar l = 0; l < CPU_LANES; l++) begin : g_lane
    assign lane_act[l] = (ACTIVE_W'(l) < lanes_eff);
    nlra_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (lane_ctl),
      .active_i (lane_act[l]),
      .free_i   (free_all[l]),
      .busy_o   (busy_w[l])
    );
  end

  nlra_merge #(
    .LANES (CPU_LANES)
  ) u_merge (
    .clk_i  (clk_i),
    .load_i (state_q == S_PREP),
    .busy_i (busy_w),
    .sum_o  (busy_sum)
  );

  // shared divider
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quo;

  // fold_mean operands: d = n + 1, h = d / 2
  logic [COUNT_BITS:0]   fd_w;
  logic [FW-1:0]         fnum;
  logic                  gap_le_h;
  logic [STALL_W-1:0]    fres;
  logic [LW-1:0]         quo_load;

  assign fd_w     = (COUNT_BITS+1)'(fn_q) + 1'b1;
  assign gap_le_h = FW'(gap_q) <= FW'(fh_q);
  assign quo_load = LW'(div_quo);

  always_comb begin
    if (ge_q) begin
      fnum = FW'(gap_q) + FW'(fh_q);
    end else if (gap_le_h) begin
      fnum = FW'(fh_q) - FW'(gap_q);
    end else begin
      // round the downward step up
      fnum = FW'(gap_q) - FW'(fh_q) + FW'(fd_q) - FW'(1);
    end
  end

  assign fres = sub_q ? (fa_q - STALL_W'(div_quo)) : (fa_q + STALL_W'(div_quo));

  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(fnum);
    div_den   = DW'(fd_q);
    case (state_q)
      S_LOAD_DIV: begin
        div_start = 1'b1;
        if (op_q == OP_MEM) begin
          div_num = (NW'(total_q - free_q) << LOAD_FRAC_BITS) + NW'(total_q >> 1);
          div_den = DW'(total_q);
        end else begin
          div_num = (NW'(busy_sum) << LOAD_FRAC_BITS) + NW'(den_cpu_q >> 1);
          div_den = DW'(den_cpu_q);
        end
      end
      S_FOLD_START: div_start = 1'b1;
      default: ;
    endcase
  end

  nlra_div #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OP_STALL;
      free_q        <= '0;
      total_q       <= '0;
      idle_q        <= 1'b0;
      lanes_q       <= '0;
      tpc_q         <= '0;
      den_cpu_q     <= '0;
      idle_run_q    <= '0;
      avg_cpu_q     <= '0;
      cpu_samples_q <= '0;
      avg_mem_q     <= '0;
      mem_samples_q <= '0;
      avg_stall_q   <= '0;
      stall_runs_q  <= '0;
      mem_now_q     <= '0;
      cpu_now_q     <= '0;
      fa_q          <= '0;
      fn_q          <= '0;
      fx_q          <= '0;
      fd_q          <= '0;
      fh_q          <= '0;
      gap_q         <= '0;
      ge_q          <= 1'b0;
      sub_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // in S_DONE the output register is handled below
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            free_q  <= free_clamped;
            total_q <= total_eff;
            idle_q  <= (in_i.payload.mem_free >= total_eff);
            lanes_q <= lanes_eff;
            tpc_q   <= tpc_eff;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          den_cpu_q <= CPU_DEN_W'(tpc_q) * CPU_DEN_W'(lanes_q);
          if (idle_q) begin
            if (idle_run_q != '1) begin
              idle_run_q <= idle_run_q + 1'b1;
            end
            op_q    <= OP_MEM;
            state_q <= S_LOAD_DIV;
          end else if (idle_run_q != '0) begin
            // first busy tick after an idle run
            fa_q    <= avg_stall_q;
            fn_q    <= stall_runs_q;
            fx_q    <= {idle_run_q, {STALL_FRAC{1'b0}}};
            op_q    <= OP_STALL;
            state_q <= S_FOLD_GAP;
          end else begin
            op_q    <= OP_MEM;
            state_q <= S_LOAD_DIV;
          end
        end
        S_LOAD_DIV: begin
          state_q <= S_WAIT_LOAD;
        end
        S_WAIT_LOAD: begin
          if (div_done) begin
            fx_q <= STALL_W'(quo_load);
            if (op_q == OP_MEM) begin
              mem_now_q <= quo_load;
              fa_q      <= STALL_W'(avg_mem_q);
              fn_q      <= mem_samples_q;
            end else begin
              cpu_now_q <= quo_load;
              fa_q      <= STALL_W'(avg_cpu_q);
              fn_q      <= cpu_samples_q;
            end
            state_q <= S_FOLD_GAP;
          end
        end
        S_FOLD_GAP: begin
          fd_q    <= fd_w;
          fh_q    <= COUNT_BITS'(fd_w >> 1);
          ge_q    <= (fx_q >= fa_q);
          gap_q   <= (fx_q >= fa_q) ? (fx_q - fa_q) : (fa_q - fx_q);
          state_q <= S_FOLD_START;
        end
        S_FOLD_START: begin
          sub_q   <= !ge_q && !gap_le_h;
          state_q <= S_WAIT_FOLD;
        end
        S_WAIT_FOLD: begin
          if (div_done) begin
            case (op_q)
              OP_STALL: begin
                avg_stall_q  <= fres;
                stall_runs_q <= count_up(stall_runs_q);
                idle_run_q   <= '0;
                op_q         <= OP_MEM;
                state_q      <= S_LOAD_DIV;
              end
              OP_MEM: begin
                avg_mem_q     <= LW'(fres);
                mem_samples_q <= count_up(mem_samples_q);
                op_q          <= OP_CPU;
                state_q       <= S_LOAD_DIV;
              end
              OP_CPU: begin
                avg_cpu_q     <= LW'(fres);
                cpu_samples_q <= count_up(cpu_samples_q);
                state_q       <= S_DONE;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid_q || out_o.ready) begin
            out_q.cpu_load_now     <= LOAD_OUT_W'(cpu_now_q);
            out_q.memory_load_now  <= LOAD_OUT_W'(mem_now_q);
            out_q.mean_cpu_load    <= LOAD_OUT_W'(avg_cpu_q);
            out_q.mean_memory_load <= LOAD_OUT_W'(avg_mem_q);
            out_q.mean_stall_ticks <= avg_stall_q;
            out_q.idle_run_ticks   <= idle_run_q;
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `NLRA_ASSERT_NEXT(a_one_word_at_a_time, in_acc, !in_i.ready, "word taken while busy")
  `NLRA_ASSERT_IMPL(a_sample_counts_agree, state_q == S_IDLE,
                    mem_samples_q == cpu_samples_q, "sample counters diverged")
  `NLRA_ASSERT_IMPL(a_means_in_range, 1'b1,
                    (avg_mem_q <= LOAD_ONE) && (avg_cpu_q <= LOAD_ONE), "mean load above one")

endmodule

### sv/nlra_lane.sv
module nlra_lane (
  input  logic                          clk_i,
  input  nlra_pkg::lane_ctl_t           ctl_i,
  input  logic                          active_i,
  input  logic [nlra_pkg::THREAD_W-1:0] free_i,
  output logic [nlra_pkg::THREAD_W-1:0] busy_o
);
  import nlra_pkg::*;

  logic [THREAD_W-1:0] free_clamped;
  logic [THREAD_W-1:0] busy_d;
  logic [THREAD_W-1:0] busy_q;

  // free count above the thread count means an idle lane
  assign free_clamped = (free_i > ctl_i.tpc) ? ctl_i.tpc : free_i;
  assign busy_d       = active_i ? (ctl_i.tpc - free_clamped) : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

### sv/nlra_merge.sv
module nlra_merge #(
  parameter int unsigned LANES = 8
) (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic [nlra_pkg::THREAD_W-1:0]   busy_i [LANES],
  output logic [nlra_pkg::BUSY_SUM_W-1:0] sum_o
);
  import nlra_pkg::*;

  logic [BUSY_SUM_W-1:0] sum_d;
  logic [BUSY_SUM_W-1:0] sum_q;

  always_comb begin
    sum_d = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_d = sum_d + BUSY_SUM_W'(busy_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### sv/nlra_div.sv
`include "node_load_running_averages_core_macros.svh"

module nlra_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             fits;

  // restoring division, one quotient bit per cycle, msb first
  assign shifted = {rem_q, acc_q[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = ~trial[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[NUM_W-2:0], fits};
      rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

  `NLRA_ASSERT_IMPL(a_start_when_free, start_i, cnt_q == '0, "divider restarted while busy")
  `NLRA_ASSERT_NEXT(a_done_after_last, cnt_q == CNT_W'(1), done_q, "missing divider done")
  `NLRA_ASSERT_IMPL(a_done_at_rest, done_q, cnt_q == '0, "done while still iterating")

endmodule
